// ===== src/pdc_pkg.sv =====
// Package for the pacing decision controller.
// It holds the field widths, the event codes and the divider sizes.
// It has no dependencies.
package pdc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 24;
    localparam int LRI_W    = 16;
    localparam int GRI_W    = 17;
    localparam int PERIOD_W = 10;
    localparam int CFG_W    = 24;
    localparam int SUM_W    = 48;
    localparam int COUNT_W  = 24;
    localparam int SLOPE_W  = 32;
    localparam int THR_W    = 51;
    localparam int DIVD_W   = 52;
    localparam int DIVS_W   = 25;

    // One neighbor difference is scaled to Q4 units per second.
    localparam int SlopeScale = 16000;

    typedef enum logic [1:0] {
        REG_LEARN_TIME = 2'd0,
        REG_LRI_LIMIT  = 2'd1,
        REG_GRI_LIMIT  = 2'd2,
        REG_PERIOD     = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        EV_NOT_READY = 3'd0,
        EV_LEARNING  = 3'd1,
        EV_THR_SET   = 3'd2,
        EV_ACTIVATE  = 3'd3,
        EV_WAITING   = 3'd4,
        EV_DET_IGN   = 3'd5,
        EV_IGNORING  = 3'd6,
        EV_PACING    = 3'd7
    } event_t;

endpackage

// ===== src/pdc_cell.sv =====
// One cell of the sample chain of the pacing decision controller.
// It holds one sample and takes its neighbor's value on each shift.
// It depends on pdc_pkg for the sample width.
module pdc_cell (
    input  logic                                clk,
    input  logic                                shift_en,
    input  logic signed [pdc_pkg::SAMPLE_W-1:0] d_in,
    output logic signed [pdc_pkg::SAMPLE_W-1:0] q
);

    logic signed [pdc_pkg::SAMPLE_W-1:0] data_reg;

    // The sample moves one place along the chain on each shift.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            data_reg <= d_in;
        end
    end

    assign q = data_reg;

endmodule

// ===== src/pdc_divider.sv =====
// Restoring divider of the pacing decision controller, one quotient bit a cycle.
// It divides unsigned magnitudes; the caller applies the sign.
// It depends on pdc_pkg for the operand widths.
module pdc_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pdc_pkg::DIVD_W-1:0]  dividend,
    input  logic [pdc_pkg::DIVS_W-1:0]  divisor,
    output logic                        done,
    output logic [pdc_pkg::DIVD_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(pdc_pkg::DIVD_W);

    logic [pdc_pkg::DIVD_W-1:0] q_reg;
    logic [pdc_pkg::DIVS_W:0]   rem_reg;
    logic [pdc_pkg::DIVS_W-1:0] div_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       run_reg;
    logic                       done_reg;
    logic [pdc_pkg::DIVS_W:0]   trial;
    logic                       fits;

    // Bring down the next dividend bit and try the subtraction.
    always_comb
    begin
        trial = {rem_reg[pdc_pkg::DIVS_W-1:0], q_reg[pdc_pkg::DIVD_W-1]};
        fits  = (trial >= {1'b0, div_reg});
    end

    // Control of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(pdc_pkg::DIVD_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Data path: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (run_reg)
        begin
            q_reg   <= {q_reg[pdc_pkg::DIVD_W-2:0], fits};
            rem_reg <= fits ? (trial - {1'b0, div_reg}) : trial;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== src/pacing_decision_controller.sv =====
// Top level of the pacing decision controller.
// It depends on pdc_pkg, pdc_cell and pdc_divider.
//
//  channel  | handshake             | beat contents
//  ---------+-----------------------+------------------------------------------------
//  input    | in_valid / in_stall   | sample, time_ms
//  output   | out_valid / out_stall | event_res, activation_seen, pace_active,
//           |                       | lri_ms, gri_ms
//  config   | cfg_we                | cfg_index, cfg_data
//
// A beat that leaves the window short goes straight to the output. A learning or a
// detection beat first rotates the sample chain once through its WINDOW cells to
// find the steepest fall, then the shared divider does the scaling. The threshold
// beat uses the divider for the mean, or skips it when no minimum was learned.
// in_stall is high while a beat is at work; a stalled result holds its register.
// After reset the window is empty and the first WINDOW - 1 beats give not_ready.
module pacing_decision_controller #(
    parameter int WINDOW = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [pdc_pkg::SAMPLE_W-1:0]  sample,
    input  logic [pdc_pkg::TIME_W-1:0]           time_ms,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [2:0]                           event_res,
    output logic                                 activation_seen,
    output logic                                 pace_active,
    output logic [pdc_pkg::LRI_W-1:0]            lri_ms,
    output logic signed [pdc_pkg::GRI_W-1:0]     gri_ms,
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_index,
    input  logic [pdc_pkg::CFG_W-1:0]            cfg_data
);

    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SCAN_W = $clog2(WINDOW);
    localparam int DIFF_W = pdc_pkg::SAMPLE_W + 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DIV    = 5'b00100,
        S_DECIDE = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        MODE_LEARN  = 2'd0,
        MODE_THR    = 2'd1,
        MODE_DETECT = 2'd2
    } mode_t;

    // Configuration registers.
    logic [pdc_pkg::TIME_W-1:0]   learn_time_reg;
    logic [pdc_pkg::LRI_W-1:0]    lri_limit_reg;
    logic [pdc_pkg::LRI_W-1:0]    gri_limit_reg;
    logic [pdc_pkg::PERIOD_W-1:0] period_cfg_reg;

    // Control and algorithm state.
    state_t                              state_reg;
    mode_t                               mode_reg;
    pdc_pkg::event_t                     ev_reg;
    logic [FILL_W-1:0]                   fill_reg;
    logic [SCAN_W-1:0]                   scan_reg;
    logic signed [DIFF_W-1:0]            min_reg;
    logic                                neg_reg;
    logic [pdc_pkg::PERIOD_W-1:0]        period_reg;
    logic signed [pdc_pkg::SUM_W-1:0]    sum_reg;
    logic [pdc_pkg::COUNT_W-1:0]         count_reg;
    logic signed [pdc_pkg::THR_W-1:0]    thr_reg;
    logic                                thr_ready_reg;
    logic                                act_reg;
    logic                                pace_reg;
    logic [pdc_pkg::LRI_W-1:0]           lri_reg;
    logic signed [pdc_pkg::GRI_W-1:0]    gri_reg;

    // Output register.
    logic                                out_valid_reg;
    logic [2:0]                          out_ev_reg;
    logic                                out_act_reg;
    logic                                out_pace_reg;
    logic [pdc_pkg::LRI_W-1:0]           out_lri_reg;
    logic signed [pdc_pkg::GRI_W-1:0]    out_gri_reg;

    logic                                accept;
    logic [FILL_W-1:0]                   fill_inc;
    logic                                shift_en;
    logic signed [pdc_pkg::SAMPLE_W-1:0] cell_q [WINDOW];
    logic signed [DIFF_W-1:0]            diff;
    logic                                scan_last;
    logic                                out_load;

    logic                                div_start;
    logic [pdc_pkg::DIVD_W-1:0]          div_dividend;
    logic [pdc_pkg::DIVS_W-1:0]          div_divisor;
    logic                                div_done;
    logic [pdc_pkg::DIVD_W-1:0]          div_quot;

    logic [DIFF_W-1:0]                   min_abs;
    logic [pdc_pkg::DIVD_W-1:0]          slope_num;
    logic signed [pdc_pkg::DIVD_W-1:0]   sum9;
    logic [pdc_pkg::DIVD_W-1:0]          sum9_abs;
    logic signed [pdc_pkg::SLOPE_W-1:0]  slope;
    logic signed [pdc_pkg::THR_W-1:0]    thr_quot;
    logic signed [pdc_pkg::SUM_W:0]      sum_wide;
    logic signed [pdc_pkg::SUM_W-1:0]    sum_sat;
    logic                                det;
    logic                                inwin;
    logic                                gri_le0;
    logic [pdc_pkg::LRI_W:0]             lri_wide;
    logic [pdc_pkg::LRI_W-1:0]           lri_step;
    logic signed [pdc_pkg::GRI_W:0]      gri_wide;
    logic signed [pdc_pkg::GRI_W-1:0]    gri_step;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign fill_inc = (fill_reg < FILL_W'(WINDOW)) ? fill_reg + 1'b1 : fill_reg;
    assign shift_en = accept || (state_reg == S_SCAN);
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_time_reg <= pdc_pkg::TIME_W'(10000);
            lri_limit_reg  <= pdc_pkg::LRI_W'(2000);
            gri_limit_reg  <= pdc_pkg::LRI_W'(1000);
            period_cfg_reg <= pdc_pkg::PERIOD_W'(10);
        end
        else if (cfg_we)
        begin
            unique case (pdc_pkg::cfg_reg_t'(cfg_index))
                pdc_pkg::REG_LEARN_TIME: learn_time_reg <= cfg_data;
                pdc_pkg::REG_LRI_LIMIT:  lri_limit_reg  <= cfg_data[pdc_pkg::LRI_W-1:0];
                pdc_pkg::REG_GRI_LIMIT:  gri_limit_reg  <= cfg_data[pdc_pkg::LRI_W-1:0];
                pdc_pkg::REG_PERIOD:     period_cfg_reg <= cfg_data[pdc_pkg::PERIOD_W-1:0];
                default:                 period_cfg_reg <= period_cfg_reg;
            endcase
        end
    end

    // Sample chain: a new sample enters at the newest end, and during the
    // scan the chain rotates so that each neighbor pair passes the oldest end.
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++)
        begin : g_cell
            logic signed [pdc_pkg::SAMPLE_W-1:0] cell_in;
            if (gi == WINDOW - 1)
            begin : g_head
                assign cell_in = accept ? sample : cell_q[0];
            end
            else
            begin : g_body
                assign cell_in = cell_q[gi + 1];
            end
            pdc_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d_in     (cell_in),
                .q        (cell_q[gi])
            );
        end
    endgenerate

    assign diff      = DIFF_W'(cell_q[1]) - DIFF_W'(cell_q[0]);
    assign scan_last = (scan_reg == SCAN_W'(WINDOW - 1));

    // Divider operands: the slope scaling or the threshold mean.
    always_comb
    begin
        min_abs      = min_reg[DIFF_W-1] ? DIFF_W'(-min_reg) : DIFF_W'(min_reg);
        slope_num    = pdc_pkg::DIVD_W'(min_abs) * pdc_pkg::DIVD_W'(pdc_pkg::SlopeScale);
        sum9         = (pdc_pkg::DIVD_W'(sum_reg) <<< 3) + pdc_pkg::DIVD_W'(sum_reg);
        sum9_abs     = sum9[pdc_pkg::DIVD_W-1] ? pdc_pkg::DIVD_W'(-sum9)
                                               : pdc_pkg::DIVD_W'(sum9);
        div_start    = 1'b0;
        div_dividend = sum9_abs;
        div_divisor  = {count_reg, 1'b0};
        if (state_reg == S_SCAN)
        begin
            div_start    = scan_last;
            div_dividend = slope_num;
            div_divisor  = pdc_pkg::DIVS_W'(period_reg);
        end
        else if (accept && (fill_inc == FILL_W'(WINDOW)) && (time_ms >= learn_time_reg)
                 && !thr_ready_reg && (count_reg != '0))
        begin
            div_start = 1'b1;
        end
    end

    pdc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Signed results and the decision terms.
    always_comb
    begin
        slope    = neg_reg ? -pdc_pkg::SLOPE_W'(div_quot) : pdc_pkg::SLOPE_W'(div_quot);
        thr_quot = neg_reg ? -pdc_pkg::THR_W'(div_quot) : pdc_pkg::THR_W'(div_quot);
        sum_wide = (pdc_pkg::SUM_W + 1)'(sum_reg) + (pdc_pkg::SUM_W + 1)'(slope);
        if (sum_wide[pdc_pkg::SUM_W] != sum_wide[pdc_pkg::SUM_W-1])
        begin
            sum_sat = sum_wide[pdc_pkg::SUM_W] ? {1'b1, {(pdc_pkg::SUM_W-1){1'b0}}}
                                               : {1'b0, {(pdc_pkg::SUM_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[pdc_pkg::SUM_W-1:0];
        end
        det      = pdc_pkg::THR_W'(slope) < thr_reg;
        inwin    = (lri_reg <= lri_limit_reg) || pace_reg;
        gri_le0  = gri_reg[pdc_pkg::GRI_W-1] || (gri_reg == '0);
        lri_wide = (pdc_pkg::LRI_W + 1)'(lri_reg) + (pdc_pkg::LRI_W + 1)'(period_reg);
        lri_step = lri_wide[pdc_pkg::LRI_W] ? {pdc_pkg::LRI_W{1'b1}}
                                            : lri_wide[pdc_pkg::LRI_W-1:0];
        gri_wide = (pdc_pkg::GRI_W + 1)'(gri_reg)
                 - (pdc_pkg::GRI_W + 1)'($signed({1'b0, period_reg}));
        gri_step = (gri_wide[pdc_pkg::GRI_W] != gri_wide[pdc_pkg::GRI_W-1])
                 ? {1'b1, {(pdc_pkg::GRI_W-1){1'b0}}} : gri_wide[pdc_pkg::GRI_W-1:0];
    end

    // Sequencer and algorithm state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_LEARN;
            ev_reg        <= pdc_pkg::EV_NOT_READY;
            fill_reg      <= '0;
            scan_reg      <= '0;
            neg_reg       <= 1'b0;
            period_reg    <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            thr_reg       <= '0;
            thr_ready_reg <= 1'b0;
            act_reg       <= 1'b0;
            pace_reg      <= 1'b0;
            lri_reg       <= '0;
            gri_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        fill_reg   <= fill_inc;
                        period_reg <= (period_cfg_reg == '0) ? pdc_pkg::PERIOD_W'(1)
                                                             : period_cfg_reg;
                        scan_reg   <= '0;
                        if (fill_inc != FILL_W'(WINDOW))
                        begin
                            ev_reg    <= pdc_pkg::EV_NOT_READY;
                            state_reg <= S_OUT;
                        end
                        else if (time_ms < learn_time_reg)
                        begin
                            mode_reg  <= MODE_LEARN;
                            state_reg <= S_SCAN;
                        end
                        else if (!thr_ready_reg)
                        begin
                            mode_reg  <= MODE_THR;
                            neg_reg   <= sum9[pdc_pkg::DIVD_W-1];
                            state_reg <= (count_reg == '0) ? S_DECIDE : S_DIV;
                        end
                        else
                        begin
                            mode_reg  <= MODE_DETECT;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    scan_reg <= scan_reg + 1'b1;
                    if (scan_last)
                    begin
                        neg_reg   <= min_reg[DIFF_W-1];
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    state_reg <= S_OUT;
                    case (mode_reg)
                        MODE_LEARN:
                        begin
                            sum_reg <= sum_sat;
                            if (count_reg != {pdc_pkg::COUNT_W{1'b1}})
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                            ev_reg <= pdc_pkg::EV_LEARNING;
                        end
                        MODE_THR:
                        begin
                            thr_reg       <= (count_reg == '0) ? '0 : thr_quot;
                            thr_ready_reg <= 1'b1;
                            ev_reg        <= pdc_pkg::EV_THR_SET;
                        end
                        default:
                        begin
                            if (inwin && !act_reg)
                            begin
                                if (det)
                                begin
                                    lri_reg  <= '0;
                                    gri_reg  <= pdc_pkg::GRI_W'(gri_limit_reg);
                                    pace_reg <= 1'b0;
                                    act_reg  <= 1'b1;
                                    ev_reg   <= pdc_pkg::EV_ACTIVATE;
                                end
                                else
                                begin
                                    lri_reg <= lri_step;
                                    gri_reg <= gri_step;
                                    ev_reg  <= pdc_pkg::EV_WAITING;
                                end
                            end
                            else if (inwin)
                            begin
                                if (det && gri_le0)
                                begin
                                    lri_reg  <= '0;
                                    gri_reg  <= pdc_pkg::GRI_W'(gri_limit_reg);
                                    pace_reg <= 1'b0;
                                    ev_reg   <= pdc_pkg::EV_ACTIVATE;
                                end
                                else
                                begin
                                    lri_reg <= lri_step;
                                    gri_reg <= gri_step;
                                    if (gri_le0)
                                    begin
                                        ev_reg <= pdc_pkg::EV_WAITING;
                                    end
                                    else if (det)
                                    begin
                                        ev_reg <= pdc_pkg::EV_DET_IGN;
                                    end
                                    else
                                    begin
                                        ev_reg <= pdc_pkg::EV_IGNORING;
                                    end
                                end
                            end
                            else
                            begin
                                pace_reg <= 1'b1;
                                ev_reg   <= pdc_pkg::EV_PACING;
                            end
                        end
                    endcase
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Running minimum of the neighbor differences; the wrap pair is skipped.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_SCAN) && !scan_last)
        begin
            if ((scan_reg == '0) || (diff < min_reg))
            begin
                min_reg <= diff;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ev_reg   <= ev_reg;
            out_act_reg  <= act_reg;
            out_pace_reg <= pace_reg;
            out_lri_reg  <= lri_reg;
            out_gri_reg  <= gri_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign event_res       = out_ev_reg;
    assign activation_seen = out_act_reg;
    assign pace_active     = out_pace_reg;
    assign lri_ms          = out_lri_reg;
    assign gri_ms          = out_gri_reg;

endmodule
